### design/plm_pkg.sv
// Shared types, constants and helpers for the prefix permit list matcher.
// No dependencies; used by plm_rule_mem and prefix_permit_list_match.
`default_nettype none

package plm_pkg;

	localparam int ADDR_W              = 32;
	localparam int PLEN_W              = 6;
	localparam int RULES_PER_LIST_DEF  = 64;
	localparam int S_TDATA_W           = 40;
	localparam int S_TUSER_W           = 2;
	localparam int M_TDATA_W           = 8;

	// Item kinds carried in s_tuser[0].
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	// List selector carried in s_tuser[1].
	localparam logic LIST_BIND    = 1'b0;
	localparam logic LIST_CONNECT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [PLEN_W-1:0] prefix;
		logic [ADDR_W-1:0] network;
	} rule_t;

	// Prefix lengths above the address width saturate to a full mask.
	function automatic logic [PLEN_W-1:0] sat_prefix(input logic [PLEN_W-1:0] plen);
		logic [PLEN_W-1:0] res;
		if (plen > PLEN_W'(ADDR_W)) begin
			res = PLEN_W'(ADDR_W);
		end else begin
			res = plen;
		end
		return res;
	endfunction

	// The low plen bits are kept since the first octet sits in bits 7:0.
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] res;
		if (plen == '0) begin
			res = '0;
		end else if (plen >= PLEN_W'(ADDR_W)) begin
			res = '1;
		end else begin
			res = {ADDR_W{1'b1}} >> (PLEN_W'(ADDR_W) - plen);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### design/prefix_permit_list_match.sv
// Top level of the prefix permit list matcher: bind and connect permit lists.
// Depends on plm_pkg and plm_rule_mem.
// An add item writes the rule unless the list is full, and its result is registered.
// A check item scans the selected list's rules in order until a hit or the list's end;
// the registered read port delivers one rule a cycle.
// Reset clears both rule counts and the handshake state; the rule memory is not cleared.
`default_nettype none

module prefix_permit_list_match #(
	parameter int RULES_PER_LIST = plm_pkg::RULES_PER_LIST_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [31:0] address, [37:32] prefix_len, [39:38] zero
	input  wire logic [plm_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] cmd, [1] list_select
	input  wire logic [plm_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [0] deny, [1] status, [7:2] zero
	output logic [plm_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam int IDX_W = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
	localparam int CNT_W = $clog2(RULES_PER_LIST + 1);
	localparam int MEM_AW = IDX_W + 1;

	plm_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]              bind_count_q, connect_count_q;
	logic [CNT_W-1:0]              idx_q;
	logic                          sel_q;
	logic [plm_pkg::ADDR_W-1:0]    addr_q;
	logic                          rd_valid_s1;
	logic                          deny_q, status_q;

	logic                          in_cmd, in_sel;
	logic [plm_pkg::ADDR_W-1:0]    in_addr;
	logic [plm_pkg::PLEN_W-1:0]    in_plen, in_plen_sat;
	logic                          accept;
	logic [CNT_W-1:0]              in_count, scan_count;
	logic                          list_full;

	logic                          wr_en;
	logic [MEM_AW-1:0]             wr_addr;
	plm_pkg::rule_t                wr_rule;
	logic                          rd_en;
	logic [MEM_AW-1:0]             rd_addr;
	plm_pkg::rule_t                rd_rule_s1;

	logic                          hit;
	logic                          scan_end;

	assign in_cmd      = s_tuser[0];
	assign in_sel      = s_tuser[1];
	assign in_addr     = s_tdata[plm_pkg::ADDR_W-1:0];
	assign in_plen     = s_tdata[plm_pkg::ADDR_W +: plm_pkg::PLEN_W];
	assign in_plen_sat = plm_pkg::sat_prefix(in_plen);

	assign accept     = s_tvalid && s_tready;
	assign in_count   = (in_sel == plm_pkg::LIST_CONNECT) ? connect_count_q : bind_count_q;
	assign scan_count = (sel_q == plm_pkg::LIST_CONNECT) ? connect_count_q : bind_count_q;
	assign list_full  = (in_count == CNT_W'(RULES_PER_LIST));

	assign wr_en           = accept && (in_cmd == plm_pkg::CMD_ADD) && !list_full;
	assign wr_addr         = {in_sel, in_count[IDX_W-1:0]};
	assign wr_rule.prefix  = in_plen_sat;
	assign wr_rule.network = in_addr & plm_pkg::prefix_mask(in_plen_sat);

	// The rule read last cycle is compared while the next one is fetched.
	assign hit = rd_valid_s1 &&
		((addr_q & plm_pkg::prefix_mask(rd_rule_s1.prefix)) == rd_rule_s1.network);
	assign scan_end = (idx_q == scan_count) && !rd_valid_s1;

	assign rd_en   = (state_q == plm_pkg::ST_SCAN) && !hit && (idx_q != scan_count);
	assign rd_addr = {sel_q, idx_q[IDX_W-1:0]};

	plm_rule_mem #(
		.AW (MEM_AW)
	) u_rule_mem (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_rule),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_rule_s1)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plm_pkg::ST_IDLE: begin
				if (accept && (in_cmd == plm_pkg::CMD_CHECK)) begin
					state_d = plm_pkg::ST_SCAN;
				end
			end
			plm_pkg::ST_SCAN: begin
				if (hit || scan_end) begin
					state_d = plm_pkg::ST_IDLE;
				end
			end
			default: state_d = plm_pkg::ST_IDLE;
		endcase
	end

	// An item is taken only when the output register is free by the next edge.
	always_comb begin
		s_tready = (state_q == plm_pkg::ST_IDLE) && (!m_tvalid || m_tready);
		m_tdata  = {{(plm_pkg::M_TDATA_W-2){1'b0}}, status_q, deny_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= plm_pkg::ST_IDLE;
			bind_count_q    <= '0;
			connect_count_q <= '0;
			idx_q           <= '0;
			rd_valid_s1     <= 1'b0;
			m_tvalid        <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (wr_en) begin
				if (in_sel == plm_pkg::LIST_CONNECT) begin
					connect_count_q <= connect_count_q + CNT_W'(1);
				end else begin
					bind_count_q <= bind_count_q + CNT_W'(1);
				end
			end
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (accept && (in_cmd == plm_pkg::CMD_ADD)) begin
				m_tvalid <= 1'b1;
			end else if ((state_q == plm_pkg::ST_SCAN) && (hit || scan_end)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q  <= in_sel;
			addr_q <= in_addr;
		end
		if (accept && (in_cmd == plm_pkg::CMD_ADD)) begin
			deny_q   <= 1'b0;
			status_q <= list_full;
		end else if ((state_q == plm_pkg::ST_SCAN) && (hit || scan_end)) begin
			deny_q   <= !hit;
			status_q <= 1'b0;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bind_count_q <= CNT_W'(RULES_PER_LIST)) &&
		(connect_count_q <= CNT_W'(RULES_PER_LIST)))
		else $error("rule count above list capacity");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plm_pkg::ST_SCAN) |-> (idx_q <= scan_count))
		else $error("scan index ran past the list end");

	a_add_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_cmd == plm_pkg::CMD_ADD)) |=> (m_tvalid && (state_q == plm_pkg::ST_IDLE)))
		else $error("add item gave no result in the next cycle");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_cmd == plm_pkg::CMD_ADD) && list_full) |=>
		($stable(bind_count_q) && $stable(connect_count_q) && status_q))
		else $error("add to a full list changed a count or was not flagged");

endmodule

`default_nettype wire

### design/plm_rule_mem.sv
// Rule store for both permit lists: one write port and one registered read port.
// Depends on plm_pkg for the rule_t entry layout.
`default_nettype none

module plm_rule_mem #(
	parameter int AW = 7
) (
	input  wire logic           clk,
	input  wire logic           wr_en,
	input  wire logic [AW-1:0]  wr_addr,
	input  wire plm_pkg::rule_t wr_data,
	input  wire logic           rd_en,
	input  wire logic [AW-1:0]  rd_addr,
	output plm_pkg::rule_t      rd_data_s1
);

	localparam int DEPTH = 1 << AW;

	plm_pkg::rule_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
